@@ rtl/ppsd_pkg.sv @@
package ppsd_pkg;

   localparam int unsigned QueueDepthDefault = 2;
   localparam int unsigned MaxTokens = 8;
   localparam int unsigned BufBits = 40;
   localparam logic [1:0] FulfilNone = 2'd2;

   // parse phases, numbered as the packed format walks them
   typedef enum logic [5:0] {
      PH_IDLE       = 6'd0,
      PH_POL_ID     = 6'd1,
      PH_POL_EFF    = 6'd2,
      PH_RULE_EXIST = 6'd3,
      PH_MAX_RULE   = 6'd4,
      PH_RULE_ID    = 6'd5,
      PH_RULE_EFF   = 6'd6,
      PH_MASK0      = 6'd7,
      PH_MASK1      = 6'd8,
      PH_MASK2      = 6'd9,
      PH_MASK3      = 6'd10,
      PH_MASK4      = 6'd11,
      PH_PERIOD     = 6'd12,
      PH_ITER       = 6'd13,
      PH_RES        = 6'd14,
      PH_ACT        = 6'd15,
      PH_MAX_COND   = 6'd16,
      PH_EXP_FUNC   = 6'd17,
      PH_EXP_EXIST  = 6'd18,
      PH_EXP_MAXIN  = 6'd19,
      PH_ATTR_TYPE  = 6'd20,
      PH_BOOL       = 6'd21,
      PH_BYTE       = 6'd22,
      PH_INT        = 6'd23,
      PH_FLOAT      = 6'd24,
      PH_LOCAL      = 6'd25,
      PH_STR_LEN    = 6'd26,
      PH_STR_CHAR   = 6'd27,
      PH_MAX_OBL    = 6'd28,
      PH_TASK_FUNC  = 6'd29,
      PH_TASK_EXIST = 6'd30,
      PH_TASK_MAXIN = 6'd31,
      PH_FUL_FLAG   = 6'd32,
      PH_FUL_BIT    = 6'd33
   } phase_type;

   // one queued input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
      logic [2:0] start_offset;
   } beat_type;

   // one result token
   typedef struct packed {
      logic [4:0]  token_kind;
      logic [31:0] token_value;
      logic [2:0]  rule_number;
      logic [2:0]  entry_number;
      logic [2:0]  input_number;
      logic [2:0]  char_number;
      logic        policy_done;
   } token_type;

   // field width of each phase
   function automatic logic [5:0] field_width(input phase_type ph);
      logic [5:0] w;
      unique case (ph)
         PH_POL_ID, PH_RULE_ID, PH_PERIOD, PH_ITER, PH_RES, PH_EXP_FUNC,
         PH_BYTE, PH_STR_CHAR, PH_TASK_FUNC:                 w = 6'd8;
         PH_MAX_RULE, PH_ACT, PH_MAX_COND, PH_EXP_MAXIN, PH_ATTR_TYPE,
         PH_LOCAL, PH_STR_LEN, PH_MAX_OBL, PH_TASK_MAXIN:    w = 6'd3;
         PH_INT:                                             w = 6'd16;
         PH_FLOAT:                                           w = 6'd32;
         PH_IDLE:                                            w = 6'd0;
         default:                                            w = 6'd1;
      endcase
      return w;
   endfunction

   // token kind of each phase
   function automatic logic [4:0] field_kind(input phase_type ph);
      logic [4:0] k;
      unique case (ph)
         PH_IDLE, PH_POL_ID:                        k = 5'd0;
         PH_BOOL, PH_BYTE, PH_INT, PH_FLOAT, PH_LOCAL: k = 5'd20;
         PH_STR_LEN:                                k = 5'd21;
         PH_STR_CHAR:                               k = 5'd22;
         PH_MAX_OBL:                                k = 5'd23;
         PH_TASK_FUNC:                              k = 5'd24;
         PH_TASK_EXIST:                             k = 5'd25;
         PH_TASK_MAXIN:                             k = 5'd26;
         PH_FUL_FLAG, PH_FUL_BIT:                   k = 5'd27;
         default:                                   k = 5'(ph - 6'd1);
      endcase
      return k;
   endfunction

   // value phase that follows an attribute type code
   function automatic phase_type type_phase(input logic [2:0] t);
      phase_type p;
      unique case (t)
         3'd0:    p = PH_BOOL;
         3'd2:    p = PH_INT;
         3'd3:    p = PH_FLOAT;
         3'd4:    p = PH_STR_LEN;
         3'd7:    p = PH_LOCAL;
         default: p = PH_BYTE;
      endcase
      return p;
   endfunction

endpackage

@@ rtl/ppsd_req_if.sv @@
interface ppsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;
   logic [2:0] start_offset;

   modport source (output valid, output data_byte, output start_req, output start_offset,
                   input ready);
   modport sink (input valid, input data_byte, input start_req, input start_offset,
                 output ready);
endinterface

@@ rtl/ppsd_rsp_if.sv @@
interface ppsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [31:0] token_value;
   logic [2:0]  rule_number;
   logic [2:0]  entry_number;
   logic [2:0]  input_number;
   logic [2:0]  char_number;
   logic        policy_done;

   modport source (output valid, output token_kind, output token_value, output rule_number,
                   output entry_number, output input_number, output char_number,
                   output policy_done, input ready);
   modport sink (input valid, input token_kind, input token_value, input rule_number,
                 input entry_number, input input_number, input char_number,
                 input policy_done, output ready);
endinterface

@@ rtl/packed_policy_stream_decoder_core.sv @@
// path: a taken beat is written to the queue, merged into the bit buffer when the parser
//   is free, and each field decoded from it is loaded into the output token register
// each beat is merged first, then its fields are decoded in turn: up to eight tokens
//   per beat, decoding stalls while a token is pending, and a set fulfil flag gives no token
// a small beat queue lets the input side run ahead while the parser works
// reset is synchronous, active high: queue empty, parser idle, no token pending
module packed_policy_stream_decoder_core
   import ppsd_pkg::*;
#(
   parameter int unsigned QueueDepth = QueueDepthDefault
) (
   input logic        clock,
   input logic        reset,
   ppsd_req_if.sink   req_ch,
   ppsd_rsp_if.source rsp_ch
);

   beat_type head;
   logic     head_valid;
   logic     head_pop;

   // front: beat acceptance and queue
   ppsd_front #(.QueueDepth(QueueDepth)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // back: bit buffer, field parser and token register
   ppsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

@@ rtl/ppsd_front.sv @@
module ppsd_front
   import ppsd_pkg::*;
#(
   parameter int unsigned QueueDepth = QueueDepthDefault
) (
   input  logic      clock,
   input  logic      reset,
   ppsd_req_if.sink  req_ch,
   output beat_type  head,
   output logic      head_valid,
   input  logic      head_pop
);

   localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntBits = $clog2(QueueDepth + 1);
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(QueueDepth - 1);
   localparam logic [CntBits-1:0] FullCnt = CntBits'(QueueDepth);

   beat_type            queue_ff [QueueDepth];
   logic [PtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic                push;
   logic                pop;
   beat_type            beat;

   // classify the incoming beat into a queue entry
   assign beat.data_byte    = req_ch.data_byte;
   assign beat.start_req    = req_ch.start_req;
   assign beat.start_offset = req_ch.start_req ? req_ch.start_offset : 3'd0;

   assign req_ch.ready = (count_ff != FullCnt);
   assign push         = req_ch.valid && req_ch.ready;
   assign head_valid   = (count_ff != '0);
   assign pop          = head_pop && head_valid;
   assign head         = queue_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= beat;
      end
   end

endmodule

@@ rtl/ppsd_back.sv @@
module ppsd_back
   import ppsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  beat_type   head,
   input  logic       head_valid,
   output logic       head_pop,
   ppsd_rsp_if.source rsp_ch
);

   logic [BufBits-1:0] buf_ff, buf_in;
   logic [5:0]         held_ff, held_in;
   phase_type          phase_ff, phase_in;
   logic [2:0]         rules_left_ff, rules_left_in;
   logic [2:0]         entries_left_ff, entries_left_in;
   logic [2:0]         inputs_left_ff, inputs_left_in;
   logic [2:0]         chars_left_ff, chars_left_in;
   logic [4:0]         masks_ff, masks_in;
   logic               task_ff, task_in;
   logic [2:0]         rule_ff, rule_in;
   logic [2:0]         entry_ff, entry_in;
   logic [2:0]         inp_ff, inp_in;
   logic [2:0]         chr_ff, chr_in;
   logic               busy_ff, busy_in;
   logic [3:0]         tok_cnt_ff, tok_cnt_in;
   logic               out_valid_ff, out_valid_in;
   token_type          out_ff, out_in;

   logic [5:0]  width;
   logic [5:0]  rest;
   logic [BufBits-1:0] shifted;
   logic [32:0] vmask;
   logic [31:0] value;
   logic        emit;
   logic        can_step;
   logic        stall;
   logic        step;
   logic        done;
   logic        out_free;

   // field extraction from the bit buffer
   assign width    = field_width(phase_ff);
   assign rest     = held_ff - width;
   assign shifted  = buf_ff >> rest;
   assign vmask    = (33'd1 << width) - 33'd1;
   assign value    = shifted[31:0] & vmask[31:0];
   assign emit     = !(phase_ff == PH_FUL_FLAG && value[0]);
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign can_step = busy_ff && (phase_ff != PH_IDLE) && (held_ff >= width)
                     && (tok_cnt_ff != 4'(MaxTokens));
   assign stall    = can_step && emit && !out_free;
   assign step     = can_step && !stall;
   assign done     = busy_ff && !can_step;
   assign head_pop = (!busy_ff || done) && head_valid;

   // parser state update: either take a new beat or decode one field
   always_comb begin
      logic attr_d, inputs_d, expr_d, obl_d, rule_d, fin;
      logic [4:0] nm;
      attr_d = 1'b0; inputs_d = 1'b0; expr_d = 1'b0;
      obl_d = 1'b0; rule_d = 1'b0; fin = 1'b0;
      nm = '0;
      buf_in          = buf_ff;
      held_in         = held_ff;
      phase_in        = phase_ff;
      rules_left_in   = rules_left_ff;
      entries_left_in = entries_left_ff;
      inputs_left_in  = inputs_left_ff;
      chars_left_in   = chars_left_ff;
      masks_in        = masks_ff;
      task_in         = task_ff;
      rule_in         = rule_ff;
      entry_in        = entry_ff;
      inp_in          = inp_ff;
      chr_in          = chr_ff;
      busy_in         = busy_ff;
      tok_cnt_in      = tok_cnt_ff;
      out_valid_in    = out_valid_ff && !rsp_ch.ready;
      out_in          = out_ff;

      if (done) begin
         busy_in = 1'b0;
      end

      if (head_pop) begin
         // merge a new beat into the buffer
         if (head.start_req) begin
            phase_in        = PH_POL_ID;
            held_in         = 6'd8 - {3'd0, head.start_offset};
            buf_in          = {32'd0, head.data_byte & (8'hFF >> head.start_offset)};
            rules_left_in   = '0;
            entries_left_in = '0;
            inputs_left_in  = '0;
            chars_left_in   = '0;
            masks_in        = '0;
            task_in         = 1'b0;
            rule_in         = '0;
            entry_in        = '0;
            inp_in          = '0;
            chr_in          = '0;
            busy_in         = 1'b1;
            tok_cnt_in      = '0;
         end else if (phase_ff != PH_IDLE) begin
            buf_in     = {buf_ff[BufBits-9:0], head.data_byte};
            held_in    = held_ff + 6'd8;
            busy_in    = 1'b1;
            tok_cnt_in = '0;
         end
      end else if (step) begin
         held_in = rest;
         buf_in  = buf_ff & ((40'd1 << rest) - 40'd1);
         if (emit) begin
            out_valid_in       = 1'b1;
            tok_cnt_in         = tok_cnt_ff + 1'b1;
            out_in.token_kind  = field_kind(phase_ff);
            out_in.token_value = (phase_ff == PH_FUL_FLAG) ? {30'd0, FulfilNone} : value;
            out_in.rule_number  = rule_ff;
            out_in.entry_number = entry_ff;
            out_in.input_number = inp_ff;
            out_in.char_number  = chr_ff;
            out_in.policy_done  = 1'b0;
         end

         unique case (phase_ff)
            PH_POL_ID:     phase_in = PH_POL_EFF;
            PH_POL_EFF:    phase_in = PH_RULE_EXIST;
            PH_RULE_EXIST: begin
               if (value[0]) phase_in = PH_MAX_RULE;
               else fin = 1'b1;
            end
            PH_MAX_RULE: begin
               rules_left_in = value[2:0];
               rule_in = '0; entry_in = '0; inp_in = '0; chr_in = '0;
               phase_in = PH_RULE_ID;
            end
            PH_RULE_ID:  phase_in = PH_RULE_EFF;
            PH_RULE_EFF: begin
               masks_in = '0;
               phase_in = PH_MASK0;
            end
            PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3: begin
               masks_in = {masks_ff[3:0], value[0]};
               phase_in = phase_type'(phase_ff + 6'd1);
            end
            PH_MASK4: begin
               nm = {masks_ff[3:0], value[0]};
               masks_in = nm;
               if (nm[4])      phase_in = PH_PERIOD;
               else if (nm[3]) phase_in = PH_ITER;
               else if (nm[2]) phase_in = PH_RES;
               else if (nm[1]) phase_in = PH_ACT;
               else            phase_in = PH_MAX_COND;
            end
            PH_PERIOD: begin
               if (masks_ff[3])      phase_in = PH_ITER;
               else if (masks_ff[2]) phase_in = PH_RES;
               else if (masks_ff[1]) phase_in = PH_ACT;
               else                  phase_in = PH_MAX_COND;
            end
            PH_ITER: begin
               if (masks_ff[2])      phase_in = PH_RES;
               else if (masks_ff[1]) phase_in = PH_ACT;
               else                  phase_in = PH_MAX_COND;
            end
            PH_RES: begin
               if (masks_ff[1]) phase_in = PH_ACT;
               else             phase_in = PH_MAX_COND;
            end
            PH_ACT: phase_in = PH_MAX_COND;
            PH_MAX_COND: begin
               entries_left_in = value[2:0];
               task_in = 1'b0;
               phase_in = PH_EXP_FUNC;
            end
            PH_EXP_FUNC: phase_in = PH_EXP_EXIST;
            PH_EXP_EXIST: begin
               if (value[0]) phase_in = PH_EXP_MAXIN;
               else expr_d = 1'b1;
            end
            PH_EXP_MAXIN, PH_TASK_MAXIN: begin
               inputs_left_in = value[2:0];
               phase_in = PH_ATTR_TYPE;
            end
            PH_ATTR_TYPE: phase_in = type_phase(value[2:0]);
            PH_BOOL, PH_BYTE, PH_INT, PH_FLOAT, PH_LOCAL: attr_d = 1'b1;
            PH_STR_LEN: begin
               chars_left_in = value[2:0];
               if (value[2:0] == 3'd0) attr_d = 1'b1;
               else phase_in = PH_STR_CHAR;
            end
            PH_STR_CHAR: begin
               chars_left_in = chars_left_ff - 1'b1;
               if (chars_left_ff == 3'd1) attr_d = 1'b1;
               else chr_in = chr_ff + 1'b1;
            end
            PH_MAX_OBL: begin
               entries_left_in = value[2:0];
               task_in = 1'b1;
               phase_in = PH_TASK_FUNC;
            end
            PH_TASK_FUNC: phase_in = PH_TASK_EXIST;
            PH_TASK_EXIST: begin
               if (value[0]) phase_in = PH_TASK_MAXIN;
               else phase_in = PH_FUL_FLAG;
            end
            PH_FUL_FLAG: begin
               if (value[0]) phase_in = PH_FUL_BIT;
               else obl_d = 1'b1;
            end
            PH_FUL_BIT: obl_d = 1'b1;
            default:    phase_in = PH_IDLE;
         endcase

         // end of an attribute
         if (attr_d) begin
            chr_in = '0;
            if (inputs_left_ff != '0) begin
               inputs_left_in = inputs_left_ff - 1'b1;
               inp_in = inp_ff + 1'b1;
               phase_in = PH_ATTR_TYPE;
            end else begin
               inputs_d = 1'b1;
            end
         end
         // end of an attribute list
         if (inputs_d) begin
            inp_in = '0;
            chr_in = '0;
            if (task_ff) phase_in = PH_FUL_FLAG;
            else expr_d = 1'b1;
         end
         // end of an expression
         if (expr_d) begin
            inp_in = '0;
            chr_in = '0;
            if (entries_left_ff != '0) begin
               entries_left_in = entries_left_ff - 1'b1;
               entry_in = entry_ff + 1'b1;
               phase_in = PH_EXP_FUNC;
            end else if (masks_ff[0]) begin
               entry_in = '0;
               phase_in = PH_MAX_OBL;
            end else begin
               rule_d = 1'b1;
            end
         end
         // end of an obligation
         if (obl_d) begin
            if (entries_left_ff != '0) begin
               entries_left_in = entries_left_ff - 1'b1;
               entry_in = entry_ff + 1'b1;
               phase_in = PH_TASK_FUNC;
            end else begin
               rule_d = 1'b1;
            end
         end
         // end of a rule
         if (rule_d) begin
            if (rules_left_ff != '0) begin
               rules_left_in = rules_left_ff - 1'b1;
               rule_in = rule_ff + 1'b1;
               entry_in = '0; inp_in = '0; chr_in = '0;
               task_in = 1'b0;
               phase_in = PH_RULE_ID;
            end else begin
               fin = 1'b1;
            end
         end
         // policy end drops the leftover bits
         if (fin) begin
            out_in.policy_done = 1'b1;
            phase_in = PH_IDLE;
            buf_in   = '0;
            held_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff          <= '0;
         held_ff         <= '0;
         phase_ff        <= PH_IDLE;
         rules_left_ff   <= '0;
         entries_left_ff <= '0;
         inputs_left_ff  <= '0;
         chars_left_ff   <= '0;
         masks_ff        <= '0;
         task_ff         <= 1'b0;
         rule_ff         <= '0;
         entry_ff        <= '0;
         inp_ff          <= '0;
         chr_ff          <= '0;
         busy_ff         <= 1'b0;
         tok_cnt_ff      <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         buf_ff          <= buf_in;
         held_ff         <= held_in;
         phase_ff        <= phase_in;
         rules_left_ff   <= rules_left_in;
         entries_left_ff <= entries_left_in;
         inputs_left_ff  <= inputs_left_in;
         chars_left_ff   <= chars_left_in;
         masks_ff        <= masks_in;
         task_ff         <= task_in;
         rule_ff         <= rule_in;
         entry_ff        <= entry_in;
         inp_ff          <= inp_in;
         chr_ff          <= chr_in;
         busy_ff         <= busy_in;
         tok_cnt_ff      <= tok_cnt_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // output token register
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.token_kind   = out_ff.token_kind;
   assign rsp_ch.token_value  = out_ff.token_value;
   assign rsp_ch.rule_number  = out_ff.rule_number;
   assign rsp_ch.entry_number = out_ff.entry_number;
   assign rsp_ch.input_number = out_ff.input_number;
   assign rsp_ch.char_number  = out_ff.char_number;
   assign rsp_ch.policy_done  = out_ff.policy_done;

endmodule

@@ bench/packed_policy_stream_decoder_core_tb.sv @@
module packed_policy_stream_decoder_core_tb
   import ppsd_pkg::*;
();

   // policy decoder model and store of tokens still to come
   class token_scoreboard;
      token_type   expected_tokens[$];
      int          errors;
      logic [63:0] field_buf;
      int          held;
      phase_type   ph;
      logic [2:0]  rules_left, entries_left, inputs_left, chars_left;
      logic [4:0]  masks;
      bit          task_ctx, ended;
      logic [2:0]  c_rule, c_entry, c_input, c_char;

      function void clear_state();
         field_buf = '0; held = 0; ph = PH_IDLE;
         rules_left = 0; entries_left = 0; inputs_left = 0; chars_left = 0;
         masks = 0; task_ctx = 0; ended = 0;
         c_rule = 0; c_entry = 0; c_input = 0; c_char = 0;
      endfunction

      function new();
         errors = 0;
         clear_state();
      endfunction

      function logic [63:0] lowbits(int w);
         return (64'd1 << w) - 64'd1;
      endfunction

      function int width_for(phase_type p);
         case (p)
            PH_POL_ID, PH_RULE_ID, PH_PERIOD, PH_ITER, PH_RES, PH_EXP_FUNC,
            PH_BYTE, PH_STR_CHAR, PH_TASK_FUNC: return 8;
            PH_MAX_RULE, PH_ACT, PH_MAX_COND, PH_EXP_MAXIN, PH_ATTR_TYPE,
            PH_LOCAL, PH_STR_LEN, PH_MAX_OBL, PH_TASK_MAXIN: return 3;
            PH_INT: return 16;
            PH_FLOAT: return 32;
            default: return 1;
         endcase
      endfunction

      function logic [4:0] kind_for(phase_type p);
         case (p)
            PH_POL_ID: return 5'd0;
            PH_BOOL, PH_BYTE, PH_INT, PH_FLOAT, PH_LOCAL: return 5'd20;
            PH_STR_LEN: return 5'd21;
            PH_STR_CHAR: return 5'd22;
            PH_MAX_OBL, PH_TASK_FUNC, PH_TASK_EXIST, PH_TASK_MAXIN,
            PH_FUL_FLAG: return 5'(p - 6'd5);
            PH_FUL_BIT: return 5'd27;
            default: return 5'(p - 6'd1);
         endcase
      endfunction

      function void finish_rule();
         if (rules_left != 0) begin
            rules_left--;
            c_rule = c_rule + 3'd1;
            c_entry = 0; c_input = 0; c_char = 0;
            task_ctx = 0;
            ph = PH_RULE_ID;
         end else begin
            ended = 1;
         end
      endfunction

      function void finish_expr();
         c_input = 0; c_char = 0;
         if (entries_left != 0) begin
            entries_left--;
            c_entry = c_entry + 3'd1;
            ph = PH_EXP_FUNC;
         end else if (masks[0]) begin
            c_entry = 0;
            ph = PH_MAX_OBL;
         end else begin
            finish_rule();
         end
      endfunction

      function void finish_obligation();
         if (entries_left != 0) begin
            entries_left--;
            c_entry = c_entry + 3'd1;
            ph = PH_TASK_FUNC;
         end else begin
            finish_rule();
         end
      endfunction

      function void finish_attr();
         c_char = 0;
         if (inputs_left != 0) begin
            inputs_left--;
            c_input = c_input + 3'd1;
            ph = PH_ATTR_TYPE;
         end else begin
            c_input = 0;
            if (task_ctx) ph = PH_FUL_FLAG;
            else finish_expr();
         end
      endfunction

      // first optional rule field enabled by the masks, from phase p on
      function phase_type optional_from(int p);
         for (int i = p; i <= PH_ACT; i++)
            if (masks[16 - i]) return phase_type'(i);
         return PH_MAX_COND;
      endfunction

      function void step_phase(phase_type p, logic [31:0] v);
         case (p)
            PH_POL_ID: ph = PH_POL_EFF;
            PH_POL_EFF: ph = PH_RULE_EXIST;
            PH_RULE_EXIST: if (v[0]) ph = PH_MAX_RULE; else ended = 1;
            PH_MAX_RULE: begin
               rules_left = v[2:0];
               c_rule = 0; c_entry = 0; c_input = 0; c_char = 0;
               ph = PH_RULE_ID;
            end
            PH_RULE_ID: ph = PH_RULE_EFF;
            PH_RULE_EFF: begin
               masks = 0;
               ph = PH_MASK0;
            end
            PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3: begin
               masks = {masks[3:0], v[0]};
               ph = phase_type'(p + 6'd1);
            end
            PH_MASK4: begin
               masks = {masks[3:0], v[0]};
               ph = optional_from(PH_PERIOD);
            end
            PH_PERIOD, PH_ITER, PH_RES, PH_ACT: ph = optional_from(p + 1);
            PH_MAX_COND: begin
               entries_left = v[2:0];
               task_ctx = 0;
               ph = PH_EXP_FUNC;
            end
            PH_EXP_FUNC: ph = PH_EXP_EXIST;
            PH_EXP_EXIST: if (v[0]) ph = PH_EXP_MAXIN; else finish_expr();
            PH_EXP_MAXIN, PH_TASK_MAXIN: begin
               inputs_left = v[2:0];
               ph = PH_ATTR_TYPE;
            end
            PH_ATTR_TYPE: begin
               case (v[2:0])
                  3'd0: ph = PH_BOOL;
                  3'd2: ph = PH_INT;
                  3'd3: ph = PH_FLOAT;
                  3'd4: ph = PH_STR_LEN;
                  3'd7: ph = PH_LOCAL;
                  default: ph = PH_BYTE;
               endcase
            end
            PH_BOOL, PH_BYTE, PH_INT, PH_FLOAT, PH_LOCAL: finish_attr();
            PH_STR_LEN: begin
               chars_left = v[2:0];
               if (chars_left == 0) finish_attr(); else ph = PH_STR_CHAR;
            end
            PH_STR_CHAR: begin
               chars_left = chars_left - 3'd1;
               if (chars_left == 0) finish_attr(); else c_char = c_char + 3'd1;
            end
            PH_MAX_OBL: begin
               entries_left = v[2:0];
               task_ctx = 1;
               ph = PH_TASK_FUNC;
            end
            PH_TASK_FUNC: ph = PH_TASK_EXIST;
            PH_TASK_EXIST: if (v[0]) ph = PH_TASK_MAXIN; else ph = PH_FUL_FLAG;
            PH_FUL_FLAG: if (v[0]) ph = PH_FUL_BIT; else finish_obligation();
            PH_FUL_BIT: finish_obligation();
            default: ph = PH_IDLE;
         endcase
      endfunction

      // accepted input beat: decode what it completes
      function void note_beat(logic [7:0] d, logic st, logic [2:0] off);
         int n, w;
         logic [31:0] v;
         token_type t;
         if (st) begin
            clear_state();
            ph = PH_POL_ID;
            held = 8 - off;
            field_buf = {56'd0, d} & lowbits(held);
         end else begin
            if (ph == PH_IDLE) return;
            field_buf = ((field_buf << 8) | {56'd0, d}) & lowbits(40);
            held += 8;
         end
         n = 0;
         while (ph != PH_IDLE && n < MaxTokens) begin
            w = width_for(ph);
            if (held < w) break;
            v = 32'((field_buf >> (held - w)) & lowbits(w));
            held -= w;
            field_buf &= lowbits(held);
            if (!(ph == PH_FUL_FLAG && v == 1)) begin
               t.token_kind = kind_for(ph);
               t.token_value = (ph == PH_FUL_FLAG) ? 32'd2 : v;
               t.rule_number = c_rule;
               t.entry_number = c_entry;
               t.input_number = c_input;
               t.char_number = c_char;
               t.policy_done = 1'b0;
               expected_tokens.push_back(t);
               n++;
            end
            ended = 0;
            step_phase(ph, v);
            if (ended) begin
               if (n > 0) expected_tokens[$].policy_done = 1'b1;
               ph = PH_IDLE;
               field_buf = '0;
               held = 0;
               ended = 0;
            end
         end
      endfunction

      // accepted token against the oldest prediction
      function void check_token(token_type got);
         token_type exp_t;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         exp_t = expected_tokens.pop_front();
         if (got.token_kind !== exp_t.token_kind || got.token_value !== exp_t.token_value ||
             got.rule_number !== exp_t.rule_number ||
             got.entry_number !== exp_t.entry_number ||
             got.input_number !== exp_t.input_number ||
             got.char_number !== exp_t.char_number ||
             got.policy_done !== exp_t.policy_done) begin
            $display("%0t: token mismatch, expected kind %0d value %h idx %0d/%0d/%0d/%0d done %0b",
                     $time, exp_t.token_kind, exp_t.token_value, exp_t.rule_number,
                     exp_t.entry_number, exp_t.input_number, exp_t.char_number,
                     exp_t.policy_done);
            $display("%0t:   actual kind %0d value %h idx %0d/%0d/%0d/%0d done %0b",
                     $time, got.token_kind, got.token_value, got.rule_number,
                     got.entry_number, got.input_number, got.char_number, got.policy_done);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ppsd_req_if req_ch();
   ppsd_rsp_if rsp_ch();

   packed_policy_stream_decoder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   token_scoreboard sb = new();
   bit   quiet = 0;
   bit   long_hold_req = 0;
   bit   rich = 0;
   int   beats_sent = 0;
   int   idle_cycles = 0;
   int   attr_turn = 0;
   bit   policy_bits[$];

   // beat and token monitors and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_beat(req_ch.data_byte, req_ch.start_req, req_ch.start_offset);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_token({rsp_ch.token_kind, rsp_ch.token_value, rsp_ch.rule_number,
                            rsp_ch.entry_number, rsp_ch.input_number, rsp_ch.char_number,
                            rsp_ch.policy_done});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 3000) begin
            $display("%0t: watchdog expired", $time);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // token receiver: random stall bursts and long hold-offs
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 0;
            rsp_ch.ready <= 1'b0;
            repeat (80) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // offer one beat and wait until it is taken
   task automatic send_beat(logic [7:0] d, logic st, logic [2:0] off);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= d;
      req_ch.start_req <= st;
      req_ch.start_offset <= off;
      do @(posedge clock); while (!req_ch.ready);
      beats_sent++;
   endtask

   task automatic put_bits(logic [31:0] v, int w);
      for (int i = w - 1; i >= 0; i--) policy_bits.push_back(v[i]);
   endtask

   function automatic logic [2:0] pick_count();
      if ($urandom_range(0, 9) < 8) return 3'($urandom_range(0, 2));
      return 3'($urandom_range(0, 7));
   endfunction

   task automatic put_attrs(logic [2:0] maxin);
      logic [2:0] ty, len;
      for (int a = 0; a <= maxin; a++) begin
         ty = rich ? 3'(attr_turn) : 3'($urandom_range(0, 7));
         if (rich) attr_turn++;
         put_bits(32'(ty), 3);
         case (ty)
            3'd0: put_bits($urandom, 1);
            3'd2: put_bits($urandom, 16);
            3'd3: put_bits($urandom, 32);
            3'd4: begin
               len = rich ? ((attr_turn & 8) ? 3'd0 : 3'd7) : 3'($urandom_range(0, 7));
               put_bits(32'(len), 3);
               for (int c = 0; c < len; c++) put_bits($urandom, 8);
            end
            3'd7: put_bits($urandom, 3);
            default: put_bits($urandom, 8);
         endcase
      end
   endtask

   // well-formed policy with random content into policy_bits
   task automatic build_policy(bit no_rules);
      logic [2:0] nrule, nexp, nobl, maxin;
      logic [4:0] m;
      bit has;
      policy_bits.delete();
      put_bits($urandom, 8);
      put_bits($urandom, 1);
      put_bits(32'(!no_rules), 1);
      if (no_rules) return;
      nrule = rich ? 3'd1 : pick_count();
      put_bits(32'(nrule), 3);
      for (int r = 0; r <= nrule; r++) begin
         put_bits($urandom, 8);
         put_bits($urandom, 1);
         m = rich ? 5'h1f : 5'($urandom);
         put_bits(32'(m), 5);
         if (m[4]) put_bits($urandom, 8);
         if (m[3]) put_bits($urandom, 8);
         if (m[2]) put_bits($urandom, 8);
         if (m[1]) put_bits($urandom, 3);
         nexp = rich ? 3'd1 : pick_count();
         put_bits(32'(nexp), 3);
         for (int e = 0; e <= nexp; e++) begin
            put_bits($urandom, 8);
            has = rich ? (e == 0) : 1'($urandom_range(0, 1));
            put_bits(32'(has), 1);
            if (has) begin
               maxin = rich ? 3'd7 : pick_count();
               put_bits(32'(maxin), 3);
               put_attrs(maxin);
            end
         end
         if (m[0]) begin
            nobl = rich ? 3'd2 : pick_count();
            put_bits(32'(nobl), 3);
            for (int o = 0; o <= nobl; o++) begin
               put_bits($urandom, 8);
               has = rich ? (o != 2) : 1'($urandom_range(0, 1));
               put_bits(32'(has), 1);
               if (has) begin
                  maxin = rich ? 3'd7 : pick_count();
                  put_bits(32'(maxin), 3);
                  put_attrs(maxin);
               end
               has = rich ? (o == 0) : 1'($urandom_range(0, 1));
               put_bits(32'(has), 1);
               if (has) put_bits($urandom, 1);
            end
         end
      end
   endtask

   // pack policy_bits behind a random lead-in and send; keep_beats < 0 sends all
   task automatic send_policy(int keep_beats);
      logic [2:0] off;
      logic [7:0] d;
      int nb;
      off = 3'($urandom_range(0, 7));
      for (int i = 0; i < off; i++) policy_bits.push_front(1'($urandom_range(0, 1)));
      while (policy_bits.size() % 8 != 0) policy_bits.push_back(1'($urandom_range(0, 1)));
      nb = policy_bits.size() / 8;
      if (keep_beats >= 0 && keep_beats < nb) nb = keep_beats;
      for (int b = 0; b < nb; b++) begin
         for (int i = 0; i < 8; i++) d[7 - i] = policy_bits[b * 8 + i];
         send_beat(d, b == 0, off);
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'd0;
      req_ch.start_req = 1'b0;
      req_ch.start_offset = 3'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle bytes, empty policy, every field type, restart mid-policy
      send_beat(8'hff, 1'b0, 3'd7);
      send_beat(8'h00, 1'b0, 3'd0);
      build_policy(1);
      send_policy(-1);
      rich = 1;
      build_policy(0);
      send_policy(-1);
      rich = 0;
      build_policy(0);
      send_policy(2);
      build_policy(1);
      send_policy(-1);
      send_beat(8'ha5, 1'b0, 3'd3);

      // random: mostly complete policies, some cut short, some noise
      while (beats_sent < 460) begin
         if (beats_sent > 200 && beats_sent < 260 && !long_hold_req) long_hold_req = 1;
         if (beats_sent > 400) quiet = 1;
         case ($urandom_range(0, 9))
            0: send_beat(8'($urandom), 1'($urandom), 3'($urandom));
            1: begin
               build_policy(0);
               send_policy($urandom_range(1, 6));
            end
            2: begin
               build_policy(1);
               send_policy(-1);
            end
            default: begin
               build_policy(0);
               send_policy(-1);
               if ($urandom_range(0, 3) == 0) send_beat(8'($urandom), 1'b0, 3'($urandom));
            end
         endcase
      end

      req_ch.valid <= 1'b0;
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
